// ===== rtl/core/c2p_pkg.sv =====
`timescale 1ns / 1ps

package c2p_pkg;

   localparam int XY_W       = 16;
   localparam int DIST_W     = 16;
   localparam int ANG_W      = 17;
   // cordic x/y: input scaled by 2^16, pre-rotation negation and gain of ~1.65
   localparam int CW         = 36;
   // angle accumulator, degrees in Q.16
   localparam int ZW         = 26;
   localparam int FRAC_SHIFT = 16;
   localparam int RAD_W      = 32;
   localparam int SQRT_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;

   localparam logic signed [ZW-1:0] HALF_TURN_Q16 = 26'sd11796480;
   localparam logic signed [ZW-1:0] ROUND_Q8      = 26'sd128;
   localparam logic signed [ZW-9:0] ANGLE_LIMIT   = 18'sd46080;
   localparam logic [RAD_W-1:0]     DIST_LIMIT    = 32'd46341;

   localparam logic signed [ZW-1:0] ATAN_Q16 [ATAN_ENTRIES] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
      26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
      26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
      26'sd917,     26'sd458,     26'sd229,    26'sd115,
      26'sd57,      26'sd29,      26'sd14,     26'sd7,
      26'sd4,       26'sd2,       26'sd1,      26'sd0
   };

   typedef struct packed {
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [ZW-1:0] z;
      logic [RAD_W-1:0]     rem;
      logic [RAD_W-1:0]     root;
   } c2p_data_type;

endpackage

// ===== rtl/core/c2p_ifs.sv =====
`timescale 1ns / 1ps

interface c2p_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [c2p_pkg::XY_W-1:0]  x_coord;
   logic signed [c2p_pkg::XY_W-1:0]  y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [c2p_pkg::DIST_W-1:0]        distance;
   logic signed [c2p_pkg::ANG_W-1:0]  angle_deg;

   modport source (output valid, output distance, output angle_deg, input ready);
   modport sink   (input valid, input distance, input angle_deg, output ready);
endinterface

// ===== rtl/core/c2p_front.sv =====
`timescale 1ns / 1ps

module c2p_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            up_valid,
   output logic                            up_ready,
   input  logic signed [c2p_pkg::XY_W-1:0] x_coord,
   input  logic signed [c2p_pkg::XY_W-1:0] y_coord,
   output logic                            dn_valid,
   input  logic                            dn_ready,
   output c2p_pkg::c2p_data_type           dn_data
);
   import c2p_pkg::*;

   logic                        sq_valid_ff;
   logic [RAD_W-2:0]            sq_x_ff, sq_y_ff;
   logic signed [CW-1:0]        cx_ff, cy_ff;
   logic signed [ZW-1:0]        z_ff;
   logic                        sum_valid_ff;
   c2p_data_type                sum_data_ff;

   logic                        sq_ready;
   logic signed [2*XY_W-1:0]    sq_x_in, sq_y_in;
   logic signed [CW-1:0]        cx_in, cy_in;
   logic signed [ZW-1:0]        z_in;
   c2p_data_type                sum_data_in;

   assign sq_ready = ~sum_valid_ff | dn_ready;
   assign up_ready = ~sq_valid_ff | sq_ready;

   always_comb begin
      sq_x_in = x_coord * x_coord;
      sq_y_in = y_coord * y_coord;
      cx_in   = CW'(x_coord) <<< FRAC_SHIFT;
      cy_in   = CW'(y_coord) <<< FRAC_SHIFT;
      z_in    = '0;
      // left half plane: turn the point by a half turn, start the angle at +/-180
      if (x_coord[XY_W-1]) begin
         cx_in = -cx_in;
         cy_in = -cy_in;
         z_in  = y_coord[XY_W-1] ? -HALF_TURN_Q16 : HALF_TURN_Q16;
      end
   end

   always_comb begin
      sum_data_in.cx   = cx_ff;
      sum_data_in.cy   = cy_ff;
      sum_data_in.z    = z_ff;
      sum_data_in.rem  = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
      sum_data_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (up_ready) sq_valid_ff <= up_valid;
         if (sq_ready) sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         sq_x_ff <= sq_x_in[RAD_W-2:0];
         sq_y_ff <= sq_y_in[RAD_W-2:0];
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         z_ff    <= z_in;
      end
      if (sq_ready && sq_valid_ff) begin
         sum_data_ff <= sum_data_in;
      end
   end

   assign dn_valid = sum_valid_ff;
   assign dn_data  = sum_data_ff;

endmodule

// ===== rtl/core/c2p_cell.sv =====
`timescale 1ns / 1ps

module c2p_cell #(
   parameter int STAGE      = 0,
   parameter int ROT_STAGES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  c2p_pkg::c2p_data_type up_data,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output c2p_pkg::c2p_data_type dn_data
);
   import c2p_pkg::*;

   localparam bit DO_ROT  = STAGE < ROT_STAGES;
   localparam bit DO_ROOT = STAGE < SQRT_STEPS;
   localparam int BIT_POS = DO_ROOT ? (RAD_W - 2 - 2 * STAGE) : 0;
   localparam logic [RAD_W-1:0] ROOT_BIT = DO_ROOT ? (RAD_W'(1) << BIT_POS) : '0;
   localparam logic signed [ZW-1:0] ATAN_STEP = ATAN_Q16[STAGE];

   logic         valid_ff;
   c2p_data_type data_ff;

   c2p_data_type         data_in;
   logic signed [CW-1:0] sh_x, sh_y;
   logic [RAD_W:0]       trial;

   assign up_ready = ~valid_ff | dn_ready;

   always_comb begin
      data_in = up_data;
      sh_x    = up_data.cx >>> STAGE;
      sh_y    = up_data.cy >>> STAGE;
      trial   = {1'b0, up_data.root} + {1'b0, ROOT_BIT};

      // a residual y of exactly zero leaves the vector where it is
      if (DO_ROT && up_data.cy != '0) begin
         if (!up_data.cy[CW-1]) begin
            data_in.cx = up_data.cx + sh_y;
            data_in.cy = up_data.cy - sh_x;
            data_in.z  = up_data.z + ATAN_STEP;
         end else begin
            data_in.cx = up_data.cx - sh_y;
            data_in.cy = up_data.cy + sh_x;
            data_in.z  = up_data.z - ATAN_STEP;
         end
      end

      if (DO_ROOT) begin
         if ({1'b0, up_data.rem} >= trial) begin
            data_in.rem  = up_data.rem - trial[RAD_W-1:0];
            data_in.root = (up_data.root >> 1) + ROOT_BIT;
         end else begin
            data_in.root = up_data.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== rtl/core/cartesian_to_polar.sv =====
// Path: a request goes through the front's squaring and sum registers, then the
// register of each cell; below 16 iterations the 16 square-root cells set the chain.
// Throughput: one point per cycle while the response side accepts, set by the chain of one-step cells.
// Each cell has its own valid flag, so holes close up under response stalls.
// Reset clears the valid flags only; datapath registers are not reset.
`timescale 1ns / 1ps

module cartesian_to_polar #(
   parameter int ITERATIONS = 16
) (
   input  logic      clock,
   input  logic      reset,
   c2p_req_if.sink   req_ch,
   c2p_rsp_if.source rsp_ch
);
   import c2p_pkg::*;

   localparam int ROT_STAGES = (ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERATIONS;
   localparam int N_CELLS    = (ROT_STAGES > SQRT_STEPS) ? ROT_STAGES : SQRT_STEPS;
   localparam logic [RAD_W-1:0] ROOT_MAX = DIST_LIMIT - RAD_W'(1);

   logic         chain_valid [N_CELLS+1];
   logic         chain_ready [N_CELLS+1];
   c2p_data_type chain_data  [N_CELLS+1];

   c2p_data_type          last;
   logic [RAD_W-1:0]      root_rnd;
   logic signed [ZW-1:0]  z_sum;
   logic signed [ZW-9:0]  z_q8;
   logic signed [ZW-9:0]  z_clamp;

   c2p_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_ch.valid),
      .up_ready (req_ch.ready),
      .x_coord  (req_ch.x_coord),
      .y_coord  (req_ch.y_coord),
      .dn_valid (chain_valid[0]),
      .dn_ready (chain_ready[0]),
      .dn_data  (chain_data[0])
   );

   for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
      c2p_cell #(
         .STAGE      (g),
         .ROT_STAGES (ROT_STAGES)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[g]),
         .up_ready (chain_ready[g]),
         .up_data  (chain_data[g]),
         .dn_valid (chain_valid[g+1]),
         .dn_ready (chain_ready[g+1]),
         .dn_data  (chain_data[g+1])
      );
   end

   assign last              = chain_data[N_CELLS];
   assign chain_ready[N_CELLS] = rsp_ch.ready;
   assign rsp_ch.valid      = chain_valid[N_CELLS];

   always_comb begin
      // round to nearest: remainder above root means past the midpoint
      root_rnd = last.root + RAD_W'(last.rem > last.root);
      if (root_rnd > DIST_LIMIT) root_rnd = DIST_LIMIT;

      z_sum = last.z + ROUND_Q8;
      z_q8  = z_sum[ZW-1:8];
      if (z_q8 > ANGLE_LIMIT) begin
         z_clamp = ANGLE_LIMIT;
      end else if (z_q8 < -ANGLE_LIMIT) begin
         z_clamp = -ANGLE_LIMIT;
      end else begin
         z_clamp = z_q8;
      end
   end

   assign rsp_ch.distance  = root_rnd[DIST_W-1:0];
   assign rsp_ch.angle_deg = z_clamp[ANG_W-1:0];

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (last.root <= ROOT_MAX))
      else $error("square root above largest possible value");

   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ({1'b0, last.rem} <= {last.root, 1'b0}))
      else $error("square root remainder exceeds twice the root");

   a_angle_span: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((last.z < (HALF_TURN_Q16 <<< 1)) && (last.z > -(HALF_TURN_Q16 <<< 1))))
      else $error("angle accumulator outside one turn");

endmodule

// ===== tb/c2p_scoreboard_pkg.sv =====
`timescale 1ns / 1ps

package c2p_scoreboard_pkg;

   typedef struct {
      logic [15:0]        distance;
      logic signed [16:0] angle_deg;
   } polar_point_t;

   class polar_scoreboard;
      int unsigned  fails;
      int unsigned  iters;
      longint       atan_step [24];
      polar_point_t expected_q [$];

      function new(int unsigned n_iter);
         fails = 0;
         iters = (n_iter > 24) ? 24 : n_iter;
         // atan(2^-i) in degrees, Q.16
         atan_step = '{
            2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1, 0
         };
      endfunction

      function void report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         fails++;
      endfunction

      function logic [15:0] nearest_distance(longint x, longint y);
         longint sq;
         longint root;
         longint trial;
         sq   = x * x + y * y;
         root = 0;
         for (int b = 15; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sq) root = trial;
         end
         // sum is an integer, so no ties
         if (sq - root * root > root) root++;
         if (root > 46341) root = 46341;
         return root[15:0];
      endfunction

      function logic signed [16:0] vector_angle(longint x, longint y);
         longint cx;
         longint cy;
         longint px;
         longint acc;
         if (x == 0 && y == 0) return '0;
         cx  = x * 65536;
         cy  = y * 65536;
         acc = 0;
         // left half plane: negate, start at +/-180
         if (x < 0) begin
            acc = (y >= 0) ? 180 * 65536 : -180 * 65536;
            cx  = -cx;
            cy  = -cy;
         end
         for (int i = 0; i < iters; i++) begin
            if (cy != 0) begin
               px = cx;
               if (cy > 0) begin
                  cx  = cx + (cy >>> i);
                  cy  = cy - (px >>> i);
                  acc = acc + atan_step[i];
               end else begin
                  cx  = cx - (cy >>> i);
                  cy  = cy + (px >>> i);
                  acc = acc - atan_step[i];
               end
            end
         end
         acc = (acc + 128) >>> 8;
         if (acc > 46080) acc = 46080;
         if (acc < -46080) acc = -46080;
         return acc[16:0];
      endfunction

      function void note_point(logic signed [15:0] x, logic signed [15:0] y);
         polar_point_t p;
         p.distance  = nearest_distance(longint'(x), longint'(y));
         p.angle_deg = vector_angle(longint'(x), longint'(y));
         expected_q.push_back(p);
      endfunction

      function void check_result(logic [15:0] distance, logic signed [16:0] angle_deg);
         polar_point_t p;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result dist=%0d ang=%0d", distance, angle_deg));
            return;
         end
         p = expected_q.pop_front();
         if (distance !== p.distance)
            report($sformatf("distance got %0d want %0d", distance, p.distance));
         if (angle_deg !== p.angle_deg)
            report($sformatf("angle_deg got %0d want %0d", angle_deg, p.angle_deg));
      endfunction
   endclass

endpackage

// ===== tb/tb_cartesian_to_polar.sv =====
`timescale 1ns / 1ps

module tb_cartesian_to_polar;
   import c2p_scoreboard_pkg::*;

   localparam int ITER      = 16;
   localparam int N_RANDOM  = 1700;
   localparam int IDLE_PCT  = 22;

   logic clock;
   logic reset;
   bit   steady;

   c2p_req_if req_ch ();
   c2p_rsp_if rsp_ch ();

   polar_scoreboard sb = new(ITER);

   cartesian_to_polar #(.ITERATIONS(ITER)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
      req_ch.valid   = 1'b1;
      req_ch.x_coord = x;
      req_ch.y_coord = y;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_point(x, y);
      @(negedge clock);
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [15:0] edge_value();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return -16'sd1;
         3: return 16'sd0;
         4: return 16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic pick_point(output logic signed [15:0] x, output logic signed [15:0] y);
      int unsigned kind;
      kind = $urandom_range(99);
      x    = 16'($urandom);
      y    = 16'($urandom);
      if (kind < 35) begin
         // full range as drawn
      end else if (kind < 55) begin
         x = 16'($signed($urandom_range(1024)) - 512);
         y = 16'($signed($urandom_range(1024)) - 512);
      end else if (kind < 65) begin
         if ($urandom_range(1)) x = '0; else y = '0;
      end else if (kind < 75) begin
         // hugging the x axis, either side
         y = 16'($signed($urandom_range(6)) - 3);
      end else if (kind < 85) begin
         y = $urandom_range(1) ? x : -x;
      end else begin
         x = edge_value();
         y = edge_value();
      end
   endtask

   // result side: stalls decided at the falling edge, transfers seen at the rising edge
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.distance, rsp_ch.angle_deg);
         @(negedge clock);
         rsp_ch.ready = steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      logic signed [15:0] x;
      logic signed [15:0] y;
      reset          = 1'b1;
      steady         = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.x_coord = '0;
      req_ch.y_coord = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // origin, both axes, corners, the +/-180 boundary
      send_point(16'sd0, 16'sd0);
      send_point(16'sd256, 16'sd0);
      send_point(16'sh7fff, 16'sd0);
      send_point(-16'sd256, 16'sd0);
      send_point(16'sh8000, 16'sd0);
      send_point(-16'sd1, 16'sd0);
      send_point(16'sd0, 16'sd1);
      send_point(16'sd0, -16'sd1);
      send_point(16'sd0, 16'sh7fff);
      send_point(16'sd0, 16'sh8000);
      send_point(16'sh7fff, 16'sh7fff);
      send_point(16'sh8000, 16'sh8000);
      send_point(16'sh8000, 16'sh7fff);
      send_point(16'sh7fff, 16'sh8000);
      send_point(-16'sd1, -16'sd1);
      send_point(-16'sd1, 16'sd1);
      send_point(16'sh8000, -16'sd1);
      send_point(16'sh8000, 16'sd1);
      send_point(16'sd1, 16'sd1);
      send_point(16'sd300, 16'sd400);
      send_point(-16'sd300, -16'sd400);
      send_point(16'shffff, 16'sh7fff);
      wait_drained();

      for (int k = 0; k < N_RANDOM; k++) begin
         steady = (k >= 700 && k < 1000);
         if (k == 350 || k == 1300) wait_drained();
         pick_point(x, y);
         send_point(x, y);
      end
      req_ch.valid = 1'b0;
      steady       = 1'b0;

      wait_drained();
      repeat (ITER + 10) @(negedge clock);
      if (sb.expected_q.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
      if (sb.fails == 0) begin
         $display("tb_cartesian_to_polar OK");
      end else begin
         $display("tb_cartesian_to_polar NOT OK");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_cartesian_to_polar NOT OK");
      $finish;
   end

endmodule
